// ===== src/ecbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecbd_pkg
// Shared types and constants of the cross bilateral denoiser.
// ----------------------------------------------------------------------------
package ecbd_pkg;

    localparam int MAX_WIDTH_DEF          = 1024;
    localparam int MAX_HEIGHT_DEF         = 1024;
    localparam int WEIGHT_TABLE_DEPTH_DEF = 256;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int RESET_DIM = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [63:0] DW_RATIO = 64'd1032607419;
    localparam int          ONE_Q16  = 65536;

    localparam int W_W   = 17;
    localparam int NUM_W = 36;
    localparam int DEN_W = 19;
    localparam int QUO_W = 16;

    typedef logic [2:0][15:0] t_rgb;

    typedef struct packed {
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
        logic [23:0]        depth;
        logic [15:0]        alpha;
        logic [15:0]        blue;
        logic [15:0]        green;
        logic [15:0]        red;
    } t_pix;

    typedef struct packed {
        logic emit;
        logic wr;
        logic par;
        logic vl;
        logic vr;
        logic vu;
        logic vd;
        logic fd;
    } t_ctl;

endpackage
`default_nettype wire

// ===== src/ecbd_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecbd_pix_if
// Input pixel channel: valid/ready with the pixel payload.
// ----------------------------------------------------------------------------
interface ecbd_pix_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [15:0]        in_red;
    logic [15:0]        in_green;
    logic [15:0]        in_blue;
    logic [15:0]        in_alpha;
    logic [23:0]        in_depth;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;

    modport source (
        output valid, action, in_red, in_green, in_blue, in_alpha, in_depth,
               normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, action, in_red, in_green, in_blue, in_alpha, in_depth,
               normal_x, normal_y, normal_z,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/ecbd_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecbd_res_if
// Result channel: valid/ready with the filtered pixel.
// ----------------------------------------------------------------------------
interface ecbd_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic        frame_done;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, frame_done,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, frame_done,
        output ready
    );
endinterface
`default_nettype wire

// ===== src/ecbd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecbd_ram
// Generic RAM: one write port, two registered read ports, read-first.
// ----------------------------------------------------------------------------
module ecbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule
`default_nettype wire

// ===== src/ecbd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecbd_ctrl
// Frame sequencer: size registers, column/row/drain counters, per-item
// issue decision and neighbour validity.
// ----------------------------------------------------------------------------
module ecbd_ctrl #(
    parameter int MAX_WIDTH  = ecbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ecbd_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ecbd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [ecbd_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                 i_take,
    input  wire logic                                 i_action,
    output ecbd_pkg::t_ctl                            o_ctl,
    output logic      [$clog2(MAX_WIDTH+1)-1:0]       o_x
);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int WW = (CW > ecbd_pkg::CFG_W) ? CW : ecbd_pkg::CFG_W;
    localparam int HW = (RW > ecbd_pkg::CFG_W) ? RW : ecbd_pkg::CFG_W;

    logic [ecbd_pkg::CFG_W-1:0] r_width;
    logic [ecbd_pkg::CFG_W-1:0] r_height;
    logic [CW-1:0]              r_col;
    logic [CW-1:0]              r_drain;
    logic [RW-1:0]              r_row;
    logic [CW-1:0]              n_col;
    logic [CW-1:0]              n_drain;
    logic [RW-1:0]              n_row;
    logic [CW-1:0]              w_eff;
    logic [RW-1:0]              h_eff;
    logic [CW-1:0]              col_inc;
    logic [CW-1:0]              drain_inc;
    logic [RW-1:0]              row_inc;
    ecbd_pkg::t_ctl             ctl;
    logic [CW-1:0]              x;

    always_comb begin
        if (r_width == '0) begin
            w_eff = CW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = RW'(1);
        end else if (HW'(r_height) > HW'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(r_height);
        end
    end

    assign col_inc   = r_col + 1'b1;
    assign drain_inc = r_drain + 1'b1;
    assign row_inc   = r_row + 1'b1;

    always_comb begin
        ctl     = '0;
        ctl.par = r_row[0];
        x       = r_col;
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        if (i_action == ecbd_pkg::ACT_PIXEL) begin
            if (r_row < h_eff && r_col < w_eff) begin
                ctl.wr   = 1'b1;
                ctl.emit = (r_row != '0);
                ctl.vl   = (r_col != '0);
                ctl.vr   = (col_inc < w_eff);
                ctl.vu   = (r_row > RW'(1));
                ctl.vd   = 1'b1;
                if (col_inc >= w_eff) begin
                    n_col = '0;
                    n_row = row_inc;
                    if (row_inc >= h_eff) begin
                        n_drain = '0;
                    end
                end else begin
                    n_col = col_inc;
                end
            end
        end else begin
            x = r_drain;
            if (r_row >= h_eff && r_drain < w_eff) begin
                ctl.emit = 1'b1;
                ctl.vl   = (r_drain != '0);
                ctl.vr   = (drain_inc < w_eff);
                ctl.vu   = (h_eff > RW'(1));
                ctl.fd   = (drain_inc >= w_eff);
                if (drain_inc >= w_eff) begin
                    n_col   = '0;
                    n_row   = '0;
                    n_drain = '0;
                end else begin
                    n_drain = drain_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ecbd_pkg::CFG_W'(ecbd_pkg::RESET_DIM);
            r_height <= ecbd_pkg::CFG_W'(ecbd_pkg::RESET_DIM);
            r_col    <= '0;
            r_row    <= '0;
            r_drain  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ecbd_pkg::REG_WIDTH: begin
                    r_width <= i_cfg_data;
                end
                ecbd_pkg::REG_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (i_take) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
        end
    end

    assign o_ctl = ctl;
    assign o_x   = x;

`ifndef SYNTHESIS
    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_eff)
        else $error("row counter beyond frame height");

    a_drain_only_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain != '0) |-> (r_row >= h_eff))
        else $error("drain counter moved without a pending last row");
`endif
endmodule
`default_nettype wire

// ===== src/ecbd_weight.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecbd_weight
// One neighbour lane: depth weight from a table times the fourth power of
// the clamped normal dot product. Five register stages.
// ----------------------------------------------------------------------------
module ecbd_weight #(
    parameter int WEIGHT_TABLE_DEPTH = ecbd_pkg::WEIGHT_TABLE_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire ecbd_pkg::t_pix            i_ctr,
    input  wire ecbd_pkg::t_pix            i_nb,
    output logic      [ecbd_pkg::W_W-1:0]  o_w
);
    localparam int WB = ecbd_pkg::W_W;
    localparam int IW = (WEIGHT_TABLE_DEPTH > 1) ? $clog2(WEIGHT_TABLE_DEPTH) : 1;

    function automatic logic [WEIGHT_TABLE_DEPTH*WB-1:0] f_table();
        logic [63:0]                   a;
        logic [WEIGHT_TABLE_DEPTH*WB-1:0] t;
        a = 64'd1 << 30;
        t = '0;
        for (int k = 0; k < WEIGHT_TABLE_DEPTH; k++) begin
            t[k*WB +: WB] = WB'((a + 64'd8192) >> 14);
            a = (a * ecbd_pkg::DW_RATIO + (64'd1 << 29)) >> 30;
        end
        return t;
    endfunction

    localparam logic [WEIGHT_TABLE_DEPTH*WB-1:0] DW_TAB = f_table();

    logic [23:0]        r_dd;
    logic signed [31:0] r_p [3];
    logic [WB-1:0]      r_n;
    logic [WB-1:0]      r_dw;
    logic [WB-1:0]      r_n2;
    logic [WB-1:0]      r_dw2;
    logic [WB-1:0]      r_nw;
    logic [WB-1:0]      r_dw3;
    logic [WB-1:0]      r_w;
    logic signed [33:0] dot;
    logic signed [33:0] dot_rnd;
    logic [WB-1:0]      n_n;
    logic [WB-1:0]      n_dw;
    logic [33:0]        sq1;
    logic [33:0]        sq2;
    logic [33:0]        prod;

    assign dot = 34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]);
    assign dot_rnd = dot + 34'sd2048;

    always_comb begin
        if (dot <= 34'sd0) begin
            n_n = '0;
        end else if (dot >= (34'sd1 <<< 28)) begin
            n_n = WB'(ecbd_pkg::ONE_Q16);
        end else begin
            n_n = dot_rnd[28:12];
        end
        if (r_dd < 24'(WEIGHT_TABLE_DEPTH)) begin
            n_dw = DW_TAB[r_dd[IW-1:0]*WB +: WB];
        end else begin
            n_dw = '0;
        end
    end

    assign sq1  = 34'(r_n) * 34'(r_n) + 34'd32768;
    assign sq2  = 34'(r_n2) * 34'(r_n2) + 34'd32768;
    assign prod = 34'(r_dw3) * 34'(r_nw) + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dd   <= (i_ctr.depth > i_nb.depth) ? i_ctr.depth - i_nb.depth
                                                 : i_nb.depth - i_ctr.depth;
            r_p[0] <= i_ctr.nx * i_nb.nx;
            r_p[1] <= i_ctr.ny * i_nb.ny;
            r_p[2] <= i_ctr.nz * i_nb.nz;
            r_n    <= n_n;
            r_dw   <= n_dw;
            r_n2   <= sq1[32:16];
            r_dw2  <= r_dw;
            r_nw   <= sq2[32:16];
            r_dw3  <= r_dw2;
            r_w    <= prod[32:16];
        end
    end

    assign o_w = r_w;
endmodule
`default_nettype wire

// ===== src/ecbd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecbd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ecbd_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [ecbd_pkg::NUM_W-1:0]   i_num,
    input  wire logic [ecbd_pkg::DEN_W-1:0]   i_den,
    output logic      [ecbd_pkg::QUO_W-1:0]   o_quot
);
    localparam int QW = ecbd_pkg::QUO_W;
    localparam int DW = ecbd_pkg::DEN_W;
    localparam int RW = ecbd_pkg::NUM_W - QW;

    logic [RW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_q   [QW];
    logic [DW-1:0] r_den [QW];
    logic [RW-1:0] s_rem [QW];
    logic [QW-1:0] s_lo  [QW];
    logic [QW-1:0] s_q   [QW];
    logic [DW-1:0] s_den [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign s_rem[k] = i_num[ecbd_pkg::NUM_W-1:QW];
            assign s_lo[k]  = i_num[QW-1:0];
            assign s_q[k]   = '0;
            assign s_den[k] = i_den;
        end else begin : g_next
            assign s_rem[k] = r_rem[k-1];
            assign s_lo[k]  = r_lo[k-1];
            assign s_q[k]   = r_q[k-1];
            assign s_den[k] = r_den[k-1];
        end

        assign trial = {s_rem[k][RW-2:0], s_lo[k][QW-1]};
        assign ge    = (trial >= RW'(s_den[k]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? trial - RW'(s_den[k]) : trial;
                r_lo[k]  <= {s_lo[k][QW-2:0], 1'b0};
                r_q[k]   <= {s_q[k][QW-2:0], ge};
                r_den[k] <= s_den[k];
            end
        end
    end

    assign o_quot = r_q[QW-1];
endmodule
`default_nettype wire

// ===== src/edge_aware_cross_bilateral_denoise.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_aware_cross_bilateral_denoise
// Four-neighbour cross bilateral filter over a raster pixel stream, with two
// line RAMs (even and odd rows); each pixel is emitted one row later.
//
//   channel  dir  payload                                       transaction
//   i_pix    in   action, rgb, alpha, depth, normal             valid & ready
//   o_res    out  filtered rgb, alpha, frame_done               valid & ready
//   i_cfg    in   register index, 11-bit data                   i_cfg_we
//
// One item per cycle while the pipeline is not held; a result passes through
// the line RAM read, the five-stage weight lanes, the weight and sum stages,
// the 16-stage divider and the output register.
// The whole pipeline holds while the output register is full and not taken.
// Reset is synchronous; line RAM contents need no clearing.
// ----------------------------------------------------------------------------
module edge_aware_cross_bilateral_denoise #(
    parameter int MAX_WIDTH          = ecbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT         = ecbd_pkg::MAX_HEIGHT_DEF,
    parameter int WEIGHT_TABLE_DEPTH = ecbd_pkg::WEIGHT_TABLE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ecbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ecbd_pkg::CFG_W-1:0]     i_cfg_data,
    ecbd_pix_if.sink                            i_pix,
    ecbd_res_if.source                          o_res
);
    localparam int AW       = $clog2(MAX_WIDTH);
    localparam int CW       = $clog2(MAX_WIDTH + 1);
    localparam int PW       = $bits(ecbd_pkg::t_pix);
    localparam int LANE_LAT = 5;
    localparam int DIV_LAT  = ecbd_pkg::QUO_W;
    localparam int WB       = ecbd_pkg::W_W;

    typedef struct packed {
        logic                  valid;
        logic                  fd;
        logic [3:0]            vmask;
        logic [15:0]           alpha;
        ecbd_pkg::t_rgb        c;
        ecbd_pkg::t_rgb [3:0]  nb;
    } t_m1;

    typedef struct packed {
        logic           valid;
        logic           fd;
        logic [15:0]    alpha;
        ecbd_pkg::t_rgb c;
    } t_m2;

    typedef struct packed {
        logic        valid;
        logic        fd;
        logic [15:0] alpha;
    } t_m3;

    logic                       en;
    logic                       take;
    ecbd_pkg::t_ctl             ctl;
    logic [CW-1:0]              x;
    logic [CW-1:0]              x1;
    ecbd_pkg::t_pix             w_pix;
    logic [PW-1:0]              ra0;
    logic [PW-1:0]              rb0;
    logic [PW-1:0]              ra1;
    logic [PW-1:0]              rb1;
    logic                       we0;
    logic                       we1;

    logic                       r_v1;
    ecbd_pkg::t_ctl             r_ctl1;
    ecbd_pkg::t_pix             r_down1;
    ecbd_pkg::t_pix             r_left;
    ecbd_pkg::t_pix             centre;
    ecbd_pkg::t_pix             nb [4];
    logic [WB-1:0]              w [4];
    t_m1                        m1;
    t_m1                        r_m1 [LANE_LAT];

    logic [32:0]                r_prod [4][3];
    logic [WB-1:0]              r_wm [4];
    t_m2                        r_m2;
    logic [ecbd_pkg::NUM_W-1:0] s_num [3];
    logic [ecbd_pkg::DEN_W-1:0] s_den;
    logic [ecbd_pkg::NUM_W-1:0] r_num [3];
    logic [ecbd_pkg::DEN_W-1:0] r_den;
    t_m3                        r_m3;
    t_m3                        r_m4 [DIV_LAT];
    logic [ecbd_pkg::QUO_W-1:0] quot [3];

    logic                       r_out_valid;
    ecbd_pkg::t_rgb             r_out_rgb;
    logic [15:0]                r_out_alpha;
    logic                       r_out_fd;

    assign en          = !r_out_valid || o_res.ready;
    assign i_pix.ready = en;
    assign take        = i_pix.valid && en;

    ecbd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_action   (i_pix.action),
        .o_ctl      (ctl),
        .o_x        (x)
    );

    always_comb begin
        w_pix       = '0;
        w_pix.red   = i_pix.in_red;
        w_pix.green = i_pix.in_green;
        w_pix.blue  = i_pix.in_blue;
        w_pix.alpha = i_pix.in_alpha;
        w_pix.depth = i_pix.in_depth;
        w_pix.nx    = i_pix.normal_x;
        w_pix.ny    = i_pix.normal_y;
        w_pix.nz    = i_pix.normal_z;
    end

    assign x1  = x + 1'b1;
    assign we0 = take && ctl.wr && !ctl.par;
    assign we1 = take && ctl.wr && ctl.par;

    ecbd_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_ram_even (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (x[AW-1:0]),
        .i_wdata   (w_pix),
        .i_re      (en),
        .i_raddr_a (x[AW-1:0]),
        .i_raddr_b (x1[AW-1:0]),
        .o_rdata_a (ra0),
        .o_rdata_b (rb0)
    );

    ecbd_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_ram_odd (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (x[AW-1:0]),
        .i_wdata   (w_pix),
        .i_re      (en),
        .i_raddr_a (x[AW-1:0]),
        .i_raddr_b (x1[AW-1:0]),
        .o_rdata_a (ra1),
        .o_rdata_b (rb1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= take && ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl1  <= ctl;
            r_down1 <= w_pix;
            if (r_v1) begin
                r_left <= centre;
            end
        end
    end

    assign centre = r_ctl1.par ? ecbd_pkg::t_pix'(ra0) : ecbd_pkg::t_pix'(ra1);
    assign nb[0]  = r_left;
    assign nb[1]  = r_ctl1.par ? ecbd_pkg::t_pix'(rb0) : ecbd_pkg::t_pix'(rb1);
    assign nb[2]  = r_ctl1.par ? ecbd_pkg::t_pix'(ra1) : ecbd_pkg::t_pix'(ra0);
    assign nb[3]  = r_down1;

    for (genvar i = 0; i < 4; i++) begin : g_lane
        ecbd_weight #(
            .WEIGHT_TABLE_DEPTH (WEIGHT_TABLE_DEPTH)
        ) u_weight (
            .i_clk (i_clk),
            .i_en  (en),
            .i_ctr (centre),
            .i_nb  (nb[i]),
            .o_w   (w[i])
        );
    end

    always_comb begin
        m1       = '0;
        m1.valid = r_v1;
        m1.fd    = r_ctl1.fd;
        m1.vmask = {r_ctl1.vd, r_ctl1.vu, r_ctl1.vr, r_ctl1.vl};
        m1.alpha = centre.alpha;
        m1.c     = {centre.blue, centre.green, centre.red};
        for (int i = 0; i < 4; i++) begin
            m1.nb[i] = {nb[i].blue, nb[i].green, nb[i].red};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANE_LAT; i++) begin
                r_m1[i] <= '0;
            end
        end else if (en) begin
            r_m1[0] <= m1;
            for (int i = 1; i < LANE_LAT; i++) begin
                r_m1[i] <= r_m1[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_wm[i] <= r_m1[LANE_LAT-1].vmask[i] ? w[i] : '0;
                for (int ch = 0; ch < 3; ch++) begin
                    r_prod[i][ch] <= r_m1[LANE_LAT-1].vmask[i]
                        ? 33'(r_m1[LANE_LAT-1].nb[i][ch]) * 33'(w[i]) : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2 <= '0;
        end else if (en) begin
            r_m2.valid <= r_m1[LANE_LAT-1].valid;
            r_m2.fd    <= r_m1[LANE_LAT-1].fd;
            r_m2.alpha <= r_m1[LANE_LAT-1].alpha;
            r_m2.c     <= r_m1[LANE_LAT-1].c;
        end
    end

    always_comb begin
        s_den = ecbd_pkg::DEN_W'(ecbd_pkg::ONE_Q16);
        for (int i = 0; i < 4; i++) begin
            s_den = s_den + ecbd_pkg::DEN_W'(r_wm[i]);
        end
        for (int ch = 0; ch < 3; ch++) begin
            s_num[ch] = {4'b0, r_m2.c[ch], 16'b0};
            for (int i = 0; i < 4; i++) begin
                s_num[ch] = s_num[ch] + ecbd_pkg::NUM_W'(r_prod[i][ch]);
            end
            s_num[ch] = s_num[ch] + ecbd_pkg::NUM_W'(s_den >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= s_den;
            for (int ch = 0; ch < 3; ch++) begin
                r_num[ch] <= s_num[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3 <= '0;
            for (int i = 0; i < DIV_LAT; i++) begin
                r_m4[i] <= '0;
            end
        end else if (en) begin
            r_m3.valid <= r_m2.valid;
            r_m3.fd    <= r_m2.fd;
            r_m3.alpha <= r_m2.alpha;
            r_m4[0]    <= r_m3;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_m4[i] <= r_m4[i-1];
            end
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_div
        ecbd_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_num[ch]),
            .i_den  (r_den),
            .o_quot (quot[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m4[DIV_LAT-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_rgb   <= {quot[2], quot[1], quot[0]};
            r_out_alpha <= r_m4[DIV_LAT-1].alpha;
            r_out_fd    <= r_m4[DIV_LAT-1].fd;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_red    = r_out_rgb[0];
    assign o_res.out_green  = r_out_rgb[1];
    assign o_res.out_blue   = r_out_rgb[2];
    assign o_res.out_alpha  = r_out_alpha;
    assign o_res.frame_done = r_out_fd;

`ifndef SYNTHESIS
    a_den_has_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m3.valid |-> (r_den >= ecbd_pkg::DEN_W'(ecbd_pkg::ONE_Q16)))
        else $error("weight sum below centre weight");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_edge_aware_cross_bilateral_denoise.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_aware_cross_bilateral_denoise
// Self-checking bench for the four-neighbour cross bilateral denoiser.
// Small frames are streamed in raster order, drained unless cut. Frame sizes
// change between phases, the clamped extremes among them. A built-in filter
// model predicts every output pixel, and each output pixel is compared with
// the oldest prediction. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_edge_aware_cross_bilateral_denoise;
    import ecbd_pkg::*;

    localparam int LINE = 1024;
    localparam int TBL  = 256;
    localparam int SETTLE = 40;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        fd;
    } t_out;

    class denoise_scoreboard;
        t_pix        lines[2*LINE];
        longint      dweight[TBL];
        int unsigned col, row, drained, width_reg, height_reg;
        t_out        pending_px[$];
        int          errors;

        function new();
            bit [63:0] a;
            a = 64'd1 << 30;
            for (int k = 0; k < TBL; k++) begin
                dweight[k] = longint'((a + 64'd8192) >> 14);
                a = (a * DW_RATIO + (64'd1 << 29)) >> 30;
            end
            col = 0; row = 0; drained = 0;
            width_reg = RESET_DIM; height_reg = RESET_DIM;
            errors = 0;
        endfunction

        function int unsigned span(int unsigned v);
            return (v < 1) ? 1 : (v > LINE) ? LINE : v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
            if (idx == REG_WIDTH) width_reg = val & 11'h7FF;
            else height_reg = val & 11'h7FF;
            col = 0; row = 0; drained = 0;
        endfunction

        function longint pair_weight(t_pix c, t_pix n);
            longint dd, dw, dot, nw;
            dd = (c.depth > n.depth) ? c.depth - n.depth : n.depth - c.depth;
            dw = (dd < TBL) ? dweight[dd] : 0;
            dot = longint'(c.nx) * longint'(n.nx) + longint'(c.ny) * longint'(n.ny)
                + longint'(c.nz) * longint'(n.nz);
            if (dot <= 0) return 0;
            nw = (dot >= (longint'(1) << 28)) ? 65536 : (dot + 2048) >>> 12;
            nw = (nw * nw + 32768) >>> 16;
            nw = (nw * nw + 32768) >>> 16;
            return (dw * nw + 32768) >>> 16;
        endfunction

        function t_out filter_px(int unsigned r, int unsigned x, int unsigned w,
                                 t_pix down, bit has_down);
            t_pix   c, nb[4];
            bit     ok[4];
            longint sr, sg, sb, sw, wt;
            t_out   o;
            c = lines[(r & 1) * LINE + x];
            ok[0] = x > 0;
            ok[1] = x + 1 < w;
            ok[2] = r >= 1;
            ok[3] = has_down;
            if (ok[0]) nb[0] = lines[(r & 1) * LINE + x - 1];
            if (ok[1]) nb[1] = lines[(r & 1) * LINE + x + 1];
            if (ok[2]) nb[2] = lines[((r - 1) & 1) * LINE + x];
            nb[3] = down;
            sr = longint'(c.red) * 65536;
            sg = longint'(c.green) * 65536;
            sb = longint'(c.blue) * 65536;
            sw = 65536;
            for (int i = 0; i < 4; i++) begin
                if (ok[i]) begin
                    wt = pair_weight(c, nb[i]);
                    sr += longint'(nb[i].red) * wt;
                    sg += longint'(nb[i].green) * wt;
                    sb += longint'(nb[i].blue) * wt;
                    sw += wt;
                end
            end
            o.red   = 16'((sr + sw / 2) / sw);
            o.green = 16'((sg + sw / 2) / sw);
            o.blue  = 16'((sb + sw / 2) / sw);
            o.alpha = c.alpha;
            o.fd    = 1'b0;
            return o;
        endfunction

        function void note_input(logic act, t_pix p);
            int unsigned w, h;
            t_out o;
            w = span(width_reg);
            h = span(height_reg);
            if (act == ACT_PIXEL) begin
                if (row >= h || col >= w) return;
                if (row >= 1) pending_px.push_back(filter_px(row - 1, col, w, p, 1'b1));
                lines[(row & 1) * LINE + col] = p;
                col++;
                if (col >= w) begin
                    col = 0;
                    row++;
                    if (row >= h) drained = 0;
                end
            end else begin
                if (row < h || drained >= w) return;
                o = filter_px(h - 1, drained, w, p, 1'b0);
                drained++;
                if (drained >= w) begin
                    o.fd = 1'b1;
                    col = 0; row = 0; drained = 0;
                end
                pending_px.push_back(o);
            end
        endfunction

        function void check_result(t_out got);
            t_out exp_px;
            if (pending_px.size() == 0) begin
                $error("unexpected output pixel");
                errors++;
                return;
            end
            exp_px = pending_px.pop_front();
            if (got.red !== exp_px.red) begin
                $error("out_red exp %0h got %0h", exp_px.red, got.red); errors++;
            end
            if (got.green !== exp_px.green) begin
                $error("out_green exp %0h got %0h", exp_px.green, got.green); errors++;
            end
            if (got.blue !== exp_px.blue) begin
                $error("out_blue exp %0h got %0h", exp_px.blue, got.blue); errors++;
            end
            if (got.alpha !== exp_px.alpha) begin
                $error("out_alpha exp %0h got %0h", exp_px.alpha, got.alpha); errors++;
            end
            if (got.fd !== exp_px.fd) begin
                $error("frame_done exp %0b got %0b", exp_px.fd, got.fd); errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ecbd_pix_if pix ();
    ecbd_res_if res ();

    edge_aware_cross_bilateral_denoise DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix.sink),
        .o_res      (res.source)
    );

    denoise_scoreboard sb = new();
    bit          gaps_on = 1'b1;
    int          rand_items;
    logic [23:0] base_depth;
    logic [15:0] base_nx, base_ny, base_nz;
    int          stall_left;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            res.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            res.ready  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out got;
        if (i_rst_n && res.valid && res.ready) begin
            got.red   = res.out_red;
            got.green = res.out_green;
            got.blue  = res.out_blue;
            got.alpha = res.out_alpha;
            got.fd    = res.frame_done;
            sb.check_result(got);
        end
    end

    function automatic logic [15:0] pick_normal(logic [15:0] base);
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return base + 16'($urandom_range(0, 2000)) - 16'd1000;
        endcase
    endfunction

    function automatic t_pix make_pixel(bit extreme);
        t_pix p;
        p.red   = 16'($urandom);
        p.green = 16'($urandom);
        p.blue  = 16'($urandom);
        p.alpha = 16'($urandom);
        if (extreme) begin
            p.red   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            p.green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            p.blue  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            p.alpha = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            p.depth = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            p.nx    = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            p.ny    = $urandom_range(0, 2) == 0 ? 16'h8000 : 16'h0000;
            p.nz    = $urandom_range(0, 1) ? 16'sd16384 : 16'h7FFF;
        end else begin
            p.depth = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                    : base_depth + 24'($urandom_range(0, 300));
            p.nx = pick_normal(base_nx);
            p.ny = pick_normal(base_ny);
            p.nz = pick_normal(base_nz);
        end
        return p;
    endfunction

    task automatic send(logic act, t_pix p);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        pix.valid    <= 1'b1;
        pix.action   <= act;
        pix.in_red   <= p.red;
        pix.in_green <= p.green;
        pix.in_blue  <= p.blue;
        pix.in_alpha <= p.alpha;
        pix.in_depth <= p.depth;
        pix.normal_x <= p.nx;
        pix.normal_y <= p.ny;
        pix.normal_z <= p.nz;
        do @(posedge i_clk); while (!pix.ready);
        sb.note_input(act, p);
        rand_items++;
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (sb.pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    // stream one frame; noise adds ignored items, cut stops part way
    task automatic run_frame(int unsigned wr, int unsigned hr, bit extreme, bit noise,
                             bit cut, bit hold_mid);
        int unsigned w, h, n;
        w = sb.span(wr);
        h = sb.span(hr);
        write_cfg(REG_WIDTH, wr);
        write_cfg(REG_HEIGHT, hr);
        base_depth = 24'($urandom);
        base_nx = 16'($urandom_range(0, 16384));
        base_ny = 16'($urandom_range(0, 16384)) - 16'd8192;
        base_nz = 16'($urandom_range(0, 16384));
        n = cut ? $urandom_range(1, w * h) : w * h;
        for (int unsigned i = 0; i < n; i++) begin
            if (noise && $urandom_range(0, 9) == 0) send(ACT_DRAIN, make_pixel(1'b0));
            if (hold_mid && i == n / 2) wait_drained();
            send(ACT_PIXEL, make_pixel(extreme));
        end
        if (cut) return;
        for (int unsigned i = 0; i < w; i++) begin
            if (noise && $urandom_range(0, 9) == 0) send(ACT_PIXEL, make_pixel(1'b0));
            send(ACT_DRAIN, make_pixel(1'b0));
        end
        if (noise) send(ACT_DRAIN, make_pixel(1'b0));
    endtask

    initial begin
        rand_items   = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_WIDTH;
        i_cfg_data   <= '0;
        pix.valid    <= 1'b0;
        pix.action   <= ACT_PIXEL;
        pix.in_red   <= '0;
        pix.in_green <= '0;
        pix.in_blue  <= '0;
        pix.in_alpha <= '0;
        pix.in_depth <= '0;
        pix.normal_x <= '0;
        pix.normal_y <= '0;
        pix.normal_z <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_frame(0, 0, 1'b1, 1'b1, 1'b0, 1'b0);
        run_frame(4, 3, 1'b1, 1'b1, 1'b0, 1'b0);
        run_frame(1, 2047, 1'b0, 1'b1, 1'b0, 1'b1);
        while (rand_items < 1750) begin
            if (rand_items > 1400) gaps_on = 1'b0;
            run_frame($urandom_range(1, 12), $urandom_range(1, 6), 1'b0,
                      $urandom_range(0, 1), $urandom_range(0, 7) == 0, 1'b0);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("edge_aware_cross_bilateral_denoise: match");
        else
            $display("edge_aware_cross_bilateral_denoise: mismatch");
        $finish;
    end

    initial begin
        #1000000;
        $display("edge_aware_cross_bilateral_denoise: mismatch");
        $finish;
    end
endmodule
